FILE: src/quaternion_arithmetic_unit_defines.svh
// assertion macros for the quaternion arithmetic unit
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define QAU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the next cycle
`define QAU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// delayed implication, the delay given by the argument n
`define QAU_ASSERT_DLY(label, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

FILE: src/qau_pkg.sv
// shared types and constants of the quaternion arithmetic unit
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

	localparam int FIELD_W       = 32;
	localparam int OP_W          = 3;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;

	// first-level operands: a field, or one minus t, which needs one more bit
	localparam int OPND_W    = FIELD_W + 1;
	// single shifted products are clamped to +-2^CLAMP_EXP
	localparam int CLAMP_EXP = 60;
	localparam int CLAMP_W   = CLAMP_EXP + 2;
	// full-precision result before saturation
	localparam int SUM_W     = 64;

	typedef enum logic [OP_W-1:0] {
		OP_PRODUCT = 3'd0,
		OP_ROTATE  = 3'd1,
		OP_ADD     = 3'd2,
		OP_LERP    = 3'd3,
		OP_DOT     = 3'd4,
		OP_CONJ    = 3'd5,
		OP_SCALE   = 3'd6
	} op_t;

endpackage

`default_nettype wire

FILE: src/qau_wide_mul.sv
// two-stage split multiplier: floor((a*b) >> FRAC_BITS), clamped to +-2^60
`timescale 1ns / 1ps
`default_nettype none

module qau_wide_mul #(
	parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF,
	parameter int A_W       = 52
) (
	input  logic                                clk,
	input  logic signed [A_W-1:0]               a,
	input  logic signed [qau_pkg::FIELD_W-1:0]  b,
	output logic signed [qau_pkg::CLAMP_W-1:0]  p
);
	import qau_pkg::*;

	localparam int LO_W  = A_W / 2;
	localparam int HI_W  = A_W - LO_W;
	localparam int LOP_W = LO_W + 1 + FIELD_W;
	localparam int HIP_W = HI_W + FIELD_W;
	localparam int MP_W  = A_W + FIELD_W;
	localparam int SH_W  = (MP_W - FRAC_BITS > CLAMP_W) ? MP_W - FRAC_BITS : CLAMP_W;
	localparam logic signed [SH_W-1:0] CLP = SH_W'(1) << CLAMP_EXP;

	logic signed [LO_W:0]      lo_a;
	logic signed [HI_W-1:0]    hi_a;
	logic signed [LOP_W-1:0]   lo_p;
	logic signed [HIP_W-1:0]   hi_p;
	logic signed [LOP_W-1:0]   lo_s4;
	logic signed [HIP_W-1:0]   hi_s4;
	logic signed [MP_W-1:0]    full;
	logic signed [SH_W-1:0]    sh;
	logic signed [SH_W-1:0]    clamped;
	logic signed [CLAMP_W-1:0] p_s5;

	// low half is unsigned, high half carries the sign
	always_comb begin
		lo_a = {1'b0, a[LO_W-1:0]};
		hi_a = a[A_W-1:LO_W];
		lo_p = LOP_W'(lo_a) * LOP_W'(b);
		hi_p = HIP_W'(hi_a) * HIP_W'(b);
	end

	always_ff @(posedge clk) begin
		lo_s4 <= lo_p;
		hi_s4 <= hi_p;
	end

	always_comb begin
		full = (MP_W'(hi_s4) <<< LO_W) + MP_W'(lo_s4);
		sh   = SH_W'(full >>> FRAC_BITS);
		if (sh > CLP) begin
			clamped = CLP;
		end else if (sh < -CLP) begin
			clamped = -CLP;
		end else begin
			clamped = sh;
		end
	end

	always_ff @(posedge clk) begin
		p_s5 <= CLAMP_W'(clamped);
	end

	assign p = p_s5;

endmodule

`default_nettype wire

FILE: src/quaternion_arithmetic_unit.sv
// top level: seven-stage fixed-point quaternion arithmetic pipeline
//
//  channel   handshake          payload
//  command   start / busy       req_type, a_w..a_z, b_w..b_z, blend_t
//  result    done (one cycle)   r_w, r_x, r_y, r_z, saturated
//
// one item is taken in every cycle; busy never rises
// each result passes through a 33x33 multiplier bank, a
// second split multiplier bank for rotation and the final sum and clip
// all operations run the same stages, so results keep item order
// reset clears only the valid bits; the data registers are not reset
// the result side must take every strobe (there is no ready input), so nothing in the pipeline ever waits
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arithmetic_unit #(
	parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = qau_pkg::WORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [qau_pkg::OP_W-1:0]           req_type,
	input  logic signed [qau_pkg::FIELD_W-1:0] a_w,
	input  logic signed [qau_pkg::FIELD_W-1:0] a_x,
	input  logic signed [qau_pkg::FIELD_W-1:0] a_y,
	input  logic signed [qau_pkg::FIELD_W-1:0] a_z,
	input  logic signed [qau_pkg::FIELD_W-1:0] b_w,
	input  logic signed [qau_pkg::FIELD_W-1:0] b_x,
	input  logic signed [qau_pkg::FIELD_W-1:0] b_y,
	input  logic signed [qau_pkg::FIELD_W-1:0] b_z,
	input  logic signed [qau_pkg::FIELD_W-1:0] blend_t,
	output logic                               done,
	output logic signed [qau_pkg::FIELD_W-1:0] r_w,
	output logic signed [qau_pkg::FIELD_W-1:0] r_x,
	output logic signed [qau_pkg::FIELD_W-1:0] r_y,
	output logic signed [qau_pkg::FIELD_W-1:0] r_z,
	output logic                               saturated
);
	import qau_pkg::*;

`include "quaternion_arithmetic_unit_defines.svh"

	localparam int P1_W = 2 * OPND_W;
	localparam int Q1_W = P1_W - FRAC_BITS;
	localparam int S_W  = Q1_W + 2;
	localparam logic signed [OPND_W-1:0] ONE_Q = OPND_W'(1) << FRAC_BITS;
	localparam logic signed [SUM_W-1:0]  W_MAX = (SUM_W'(1) <<< (WORD_BITS - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0]  W_MIN = ~W_MAX;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// stage 1: capture item, form one minus t
	op_t                       op_s1;
	logic signed [FIELD_W-1:0] a_s1 [4];
	logic signed [FIELD_W-1:0] b_s1 [4];
	logic signed [FIELD_W-1:0] t_s1;
	logic signed [OPND_W-1:0]  omt_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_t'(req_type);
			a_s1[0] <= a_w;
			a_s1[1] <= a_x;
			a_s1[2] <= a_y;
			a_s1[3] <= a_z;
			b_s1[0] <= b_w;
			b_s1[1] <= b_x;
			b_s1[2] <= b_y;
			b_s1[3] <= b_z;
			t_s1   <= blend_t;
			omt_s1 <= ONE_Q - OPND_W'(blend_t);
		end
	end

	// stage 2: 4x4 multiplier bank, slot [i][j] defaults to a_i * b_j
	logic signed [OPND_W-1:0] opa [4][4];
	logic signed [OPND_W-1:0] opb [4][4];
	logic signed [P1_W-1:0]   prod [4][4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				opa[i][j] = OPND_W'(a_s1[i]);
				opb[i][j] = OPND_W'(b_s1[j]);
				case (op_s1)
					OP_ROTATE: begin
						// b_w column becomes the squares of a
						if (j == 0) begin
							opb[i][j] = OPND_W'(a_s1[i]);
						end
					end
					OP_LERP: begin
						if (j == 0) begin
							opb[i][j] = omt_s1;
						end else if (j == 1) begin
							opa[i][j] = OPND_W'(b_s1[i]);
							opb[i][j] = OPND_W'(t_s1);
						end
					end
					OP_SCALE: begin
						if (j == 0) begin
							opb[i][j] = OPND_W'(t_s1);
						end
					end
					default: begin
					end
				endcase
				prod[i][j] = P1_W'(opa[i][j]) * P1_W'(opb[i][j]);
			end
		end
	end

	op_t                       op_s2;
	logic signed [FIELD_W-1:0] a_s2 [4];
	logic signed [FIELD_W-1:0] b_s2 [4];
	logic signed [Q1_W-1:0]    q_s2 [4][4];

	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		for (int i = 0; i < 4; i++) begin
			a_s2[i] <= a_s1[i];
			b_s2[i] <= b_s1[i];
			for (int j = 0; j < 4; j++) begin
				q_s2[i][j] <= Q1_W'(prod[i][j] >>> FRAC_BITS);
			end
		end
	end

	// stage 3: first-level sums
	logic signed [S_W-1:0] qe [4][4];
	logic signed [S_W-1:0] lvl1 [4];
	logic signed [S_W-1:0] rot_s, rot_d;
	logic signed [S_W-1:0] rot_c [3];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				qe[i][j] = S_W'(q_s2[i][j]);
			end
		end
		// rotation: w^2 - |u|^2, u.v and u x v
		rot_s    = qe[0][0] - qe[1][0] - qe[2][0] - qe[3][0];
		rot_d    = qe[1][1] + qe[2][2] + qe[3][3];
		rot_c[0] = qe[2][3] - qe[3][2];
		rot_c[1] = qe[3][1] - qe[1][3];
		rot_c[2] = qe[1][2] - qe[2][1];
		for (int i = 0; i < 4; i++) begin
			lvl1[i] = '0;
		end
		case (op_s2)
			OP_PRODUCT: begin
				lvl1[0] = qe[0][0] - qe[1][1] - qe[2][2] - qe[3][3];
				lvl1[1] = qe[0][1] + qe[1][0] + qe[2][3] - qe[3][2];
				lvl1[2] = qe[0][2] - qe[1][3] + qe[2][0] + qe[3][1];
				lvl1[3] = qe[0][3] + qe[1][2] - qe[2][1] + qe[3][0];
			end
			OP_ADD: begin
				for (int i = 0; i < 4; i++) begin
					lvl1[i] = S_W'(a_s2[i]) + S_W'(b_s2[i]);
				end
			end
			OP_LERP: begin
				for (int i = 0; i < 4; i++) begin
					lvl1[i] = qe[i][0] + qe[i][1];
				end
			end
			OP_DOT: begin
				lvl1[0] = qe[0][0] + qe[1][1] + qe[2][2] + qe[3][3];
			end
			OP_CONJ: begin
				lvl1[0] = S_W'(a_s2[0]);
				for (int i = 1; i < 4; i++) begin
					lvl1[i] = -S_W'(a_s2[i]);
				end
			end
			OP_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					lvl1[i] = qe[i][0];
				end
			end
			default: begin
			end
		endcase
	end

	op_t                       op_s3;
	logic signed [S_W-1:0]     r1_s3 [4];
	logic signed [S_W-1:0]     s_s3, d_s3;
	logic signed [S_W-1:0]     c_s3 [3];
	logic signed [FIELD_W-1:0] a_s3 [4];
	logic signed [FIELD_W-1:0] v_s3 [3];

	always_ff @(posedge clk) begin
		op_s3 <= op_s2;
		s_s3  <= rot_s;
		d_s3  <= rot_d;
		for (int i = 0; i < 4; i++) begin
			r1_s3[i] <= lvl1[i];
			a_s3[i]  <= a_s2[i];
		end
		for (int i = 0; i < 3; i++) begin
			c_s3[i] <= rot_c[i];
			v_s3[i] <= b_s2[i+1];
		end
	end

	// stages 4 and 5: nine rotation products through split multipliers
	logic signed [S_W-1:0]     wide_op [9];
	logic signed [FIELD_W-1:0] narrow_op [9];
	logic signed [CLAMP_W-1:0] mq [9];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			wide_op[k]     = s_s3;
			narrow_op[k]   = v_s3[k];
			wide_op[k+3]   = c_s3[k];
			narrow_op[k+3] = a_s3[0];
			wide_op[k+6]   = d_s3;
			narrow_op[k+6] = a_s3[k+1];
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_rot_mul
		qau_wide_mul #(
			.FRAC_BITS (FRAC_BITS),
			.A_W       (S_W)
		) u_mul (
			.clk (clk),
			.a   (wide_op[k]),
			.b   (narrow_op[k]),
			.p   (mq[k])
		);
	end

	op_t                   op_s4, op_s5;
	logic signed [S_W-1:0] r1_s4 [4];
	logic signed [S_W-1:0] r1_s5 [4];

	always_ff @(posedge clk) begin
		op_s4 <= op_s3;
		op_s5 <= op_s4;
		for (int i = 0; i < 4; i++) begin
			r1_s4[i] <= r1_s3[i];
			r1_s5[i] <= r1_s4[i];
		end
	end

	// stage 6: rotation sum s*v + 2w(u x v) + 2(u.v)u, or pass first-level result
	logic signed [SUM_W-1:0] r_nxt [4];
	logic signed [SUM_W-1:0] r_s6 [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			r_nxt[i] = SUM_W'(r1_s5[i]);
		end
		if (op_s5 == OP_ROTATE) begin
			r_nxt[0] = '0;
			for (int i = 0; i < 3; i++) begin
				r_nxt[i+1] = SUM_W'(mq[i]) + (SUM_W'(mq[i+3]) <<< 1)
					+ (SUM_W'(mq[i+6]) <<< 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			r_s6[i] <= r_nxt[i];
		end
	end

	// stage 7: clip to WORD_BITS
	logic [3:0]                fit;
	logic                      fit_all;
	logic signed [SUM_W-1:0]   clip [4];
	logic signed [FIELD_W-1:0] res_s7 [4];
	logic                      sat_s7;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			fit[i]  = (&r_s6[i][SUM_W-1:WORD_BITS-1]) | ~(|r_s6[i][SUM_W-1:WORD_BITS-1]);
			clip[i] = fit[i] ? r_s6[i] : (r_s6[i][SUM_W-1] ? W_MIN : W_MAX);
		end
		fit_all = &fit;
	end

	always_ff @(posedge clk) begin
		sat_s7 <= ~fit_all;
		for (int i = 0; i < 4; i++) begin
			res_s7[i] <= clip[i][FIELD_W-1:0];
		end
	end

	assign done      = valid_s7;
	assign r_w       = res_s7[0];
	assign r_x       = res_s7[1];
	assign r_y       = res_s7[2];
	assign r_z       = res_s7[3];
	assign saturated = sat_s7;

	`QAU_ASSERT_DLY(a_item_latency, accept, 7, done, "accepted item did not reach the result")
	`QAU_ASSERT_DLY(a_dot_vector_zero, valid_s5 && op_s5 == OP_DOT, 2, done && r_x == 0 && r_y == 0 && r_z == 0, "dot item left vector part nonzero")
	`QAU_ASSERT_DLY(a_rot_scalar_zero, valid_s5 && op_s5 == OP_ROTATE, 2, done && r_w == 0, "rotate item left scalar part nonzero")
	`QAU_ASSERT_NXT(a_no_false_clip, valid_s6 && fit_all, done && !saturated, "in-range item flagged as clipped")

endmodule

`default_nettype wire
